// ===== rtl/core/swm_pkg.sv =====
// Shared widths and divider handshake types for the sliding window mean block.
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int WINDOW_W = 9;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/swm_div.sv =====
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module swm_div
    import swm_pkg::*;
#(
    parameter int SUM_W = 40,
    parameter int CNT_W = 9
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [SUM_W-1:0]    dividend,
    input  wire logic        [CNT_W-1:0]    divisor,
    output      div_status_t                status,
    output      logic        [SAMPLE_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [STEP_W-1:0]   count_reg;
    logic [STEP_W-1:0]   count_next;
    logic [SUM_W-1:0]    quo_reg;
    logic [SUM_W-1:0]    quo_next;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    rem_next;
    logic [CNT_W-1:0]    dsr_reg;
    logic [CNT_W-1:0]    dsr_next;
    logic                neg_reg;
    logic                neg_next;
    logic [SAMPLE_W-1:0] res_reg;
    logic [SAMPLE_W-1:0] res_next;

    logic [CNT_W:0]      rem_sh;
    logic [CNT_W:0]      rem_diff;
    logic                ge;
    logic [SUM_W-1:0]    mag;
    logic [SUM_W-1:0]    q_signed;

    assign rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, dsr_reg};
    assign ge       = (rem_sh >= {1'b0, dsr_reg});
    assign mag      = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    assign q_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = STEP_W'(SUM_W);
            quo_next   = mag;
            rem_next   = '0;
            dsr_next   = divisor;
            neg_next   = dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = q_signed[SAMPLE_W-1:0];
            end
            else
            begin
                count_next = count_reg - 1'b1;
                quo_next   = {quo_reg[SUM_W-2:0], ge};
                rem_next   = ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_mean.sv =====
// Top level of the sliding window mean: ring buffer in memory, running sum, serial divide.
//
//  Channel  Signals                          Carries
//  -------  -------------------------------  --------------------------------
//  s_*      s_tvalid s_tready s_tdata[31:0]  input item: sample (Q16.16)
//  m_*      m_tvalid m_tready m_tdata[31:0]  result item: mean (Q16.16)
//  cfg_*    cfg_valid cfg_ready cfg_data[8:0] window_length register write
//
// While the window fills, an item passes S_ADJ, S_DSTART, S_DIV (the serial divide) and
// S_OUT, and a new item is accepted only back in S_IDLE; a full window adds S_REPL.
// Each sample dropped after the window has been shortened adds a pass through S_TRIM and S_ADJ.
// A zero window skips the divide: the sample goes from S_OUT into the output register.
// Reset empties the window; the sample memory needs no clearing.
// A result waits in the output register while the next item is accepted and computed.
`default_nettype none

module sliding_window_mean
    import swm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 256
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    input  wire logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    output      logic [SAMPLE_W-1:0] m_tdata,   // [31:0] mean
    input  wire logic                cfg_valid,
    output      logic                cfg_ready,
    input  wire logic [WINDOW_W-1:0] cfg_data
);

    localparam int LOG_D  = $clog2(WINDOW_DEPTH);
    localparam int ADDR_W = (LOG_D > 0) ? LOG_D : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + LOG_D;
    localparam int WIDE_W = (CNT_W > WINDOW_W) ? CNT_W : WINDOW_W;

    localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(WINDOW_DEPTH);
    localparam logic [WIDE_W-1:0] DEPTH_W  = WIDE_W'(WINDOW_DEPTH);
    localparam logic [CNT_W:0]    DEPTH_X  = (CNT_W + 1)'(WINDOW_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(WINDOW_DEPTH - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADJ    = 3'd1;
    localparam logic [2:0] S_TRIM   = 3'd2;
    localparam logic [2:0] S_REPL   = 3'd3;
    localparam logic [2:0] S_DSTART = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [WINDOW_W-1:0]        win_reg;
    logic [ADDR_W-1:0]          oldest_reg;
    logic [ADDR_W-1:0]          oldest_next;
    logic [CNT_W-1:0]           held_reg;
    logic [CNT_W-1:0]           held_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic [SAMPLE_W-1:0]        res_reg;
    logic [SAMPLE_W-1:0]        res_next;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic [SAMPLE_W-1:0]        m_data_reg;
    logic [SAMPLE_W-1:0]        m_data_next;

    logic [SAMPLE_W-1:0]        mem [WINDOW_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;

    logic [CNT_W-1:0]           target;
    logic [CNT_W:0]             pos_sum;
    logic [CNT_W:0]             pos_wrap;
    logic [ADDR_W-1:0]          append_pos;
    logic [ADDR_W-1:0]          oldest_inc;
    logic signed [SUM_W-1:0]    sample_ext;
    logic signed [SUM_W-1:0]    old_ext;
    logic                       in_acc;
    logic                       out_free;

    div_status_t                div_status;
    logic [SAMPLE_W-1:0]        div_quotient;
    logic                       div_start;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign div_start = (state_reg == S_DSTART);

    assign target = (WIDE_W'(win_reg) > DEPTH_W) ? DEPTH_C : CNT_W'(win_reg);

    assign pos_sum    = (CNT_W + 1)'(oldest_reg) + (CNT_W + 1)'(held_reg);
    assign pos_wrap   = (pos_sum >= DEPTH_X) ? (pos_sum - DEPTH_X) : pos_sum;
    assign append_pos = ADDR_W'(pos_wrap);
    assign oldest_inc = (oldest_reg == LAST_POS) ? '0 : (oldest_reg + 1'b1);
    assign sample_ext = SUM_W'(sample_reg);
    assign old_ext    = SUM_W'(rd_data_reg);

    always_comb
    begin
        state_next   = state_reg;
        oldest_next  = oldest_reg;
        held_next    = held_reg;
        sum_next     = sum_reg;
        sample_next  = sample_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = oldest_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    sample_next = s_tdata;
                    res_next    = s_tdata;
                    state_next  = (win_reg == '0) ? S_OUT : S_ADJ;
                end
            end
            S_ADJ:
            begin
                priority if (held_reg > target)
                begin
                    state_next = S_TRIM;
                end
                else if (held_reg < target)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = append_pos;
                    held_next  = held_reg + 1'b1;
                    sum_next   = sum_reg + sample_ext;
                    state_next = S_DSTART;
                end
                else
                begin
                    state_next = S_REPL;
                end
            end
            S_TRIM:
            begin
                sum_next    = sum_reg - old_ext;
                oldest_next = oldest_inc;
                held_next   = held_reg - 1'b1;
                state_next  = S_ADJ;
            end
            S_REPL:
            begin
                mem_we      = 1'b1;
                mem_waddr   = oldest_reg;
                sum_next    = sum_reg - old_ext + sample_ext;
                oldest_next = oldest_inc;
                state_next  = S_DSTART;
            end
            S_DSTART:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    res_next   = div_quotient;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            win_reg     <= '0;
            oldest_reg  <= '0;
            held_reg    <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            held_reg    <= held_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                win_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= sample_reg;
        end
        rd_data_reg <= mem[oldest_reg];
    end

    swm_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (held_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

endmodule

`default_nettype wire
